### rtl/vdc_pkg.sv
// ============================================================================
// vdc_pkg
// Shared types and codes of the video display controller register block.
// ============================================================================
`default_nettype none

package vdc_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_RSVD  = 2'd3
    } req_t;

    // Controller register select, low three address bits
    typedef enum logic [2:0] {
        REG_INIT   = 3'd0,
        REG_CMD    = 3'd1,
        REG_FS_LO  = 3'd2,
        REG_FS_HI  = 3'd3,
        REG_CUR_LO = 3'd4,
        REG_CUR_HI = 3'd5,
        REG_SS_LO  = 3'd6,
        REG_SS_HI  = 3'd7
    } reg_sel_t;

    // Address bits
    localparam int ADDR_CTRL_BIT  = 4;
    localparam int ADDR_COLOR_BIT = 3;

    // Init register indexes
    localparam logic [3:0] INIT_ROWS   = 4'd4;
    localparam logic [3:0] INIT_COLS   = 4'd5;
    localparam logic [3:0] INIT_PTR_LO = 4'd10;
    localparam logic [3:0] INIT_PTR_HI = 4'd11;
    localparam logic [3:0] INIT_LAST   = 4'd14;

    // Command codes and decode masks
    localparam logic [7:0] CMD_RESET       = 8'h00;
    localparam logic [7:0] CMD_WR_PTR      = 8'hA2;
    localparam logic [7:0] CMD_INC_CUR     = 8'hA9;
    localparam logic [7:0] CMD_WR_CUR      = 8'hAA;
    localparam logic [7:0] CMD_WR_CUR_INC  = 8'hAB;
    localparam logic [7:0] MASK_SET_INDEX  = 8'hF0;
    localparam logic [7:0] PAT_SET_INDEX   = 8'h10;
    localparam logic [7:0] MASK_DISPLAY    = 8'hE9;
    localparam logic [7:0] PAT_DISPLAY_OFF = 8'h28;
    localparam logic [7:0] PAT_DISPLAY_ON  = 8'h29;
    localparam logic [7:0] MASK_CURSOR     = 8'hF1;
    localparam logic [7:0] PAT_CURSOR_OFF  = 8'h30;
    localparam logic [7:0] PAT_CURSOR_ON   = 8'h31;

    // Read values
    localparam logic [7:0] RD_UNMAPPED    = 8'hFF;
    localparam logic [7:0] STAT_READY     = 8'h02;
    localparam logic [7:0] STAT_BLANK     = 8'h10;
    localparam logic [7:0] STAT_CMD_READY = 8'h20;

    localparam int ADDR_W  = 14;
    localparam int COUNT_W = 4;

    // Controller state
    typedef struct packed {
        logic [3:0]        init_index;
        logic              initializing;
        logic              busy;
        logic              disp_enable;
        logic              cursor_on;
        logic              blanking;
        logic [2:0]        tick_phase;
        logic [COUNT_W-1:0] countdown;
        logic [ADDR_W-1:0] write_target;
        logic [7:0]        char_byte;
        logic [7:0]        attr_byte;
        logic [ADDR_W-1:0] pointer_address;
        logic [ADDR_W-1:0] cursor_address;
        logic [15:0]       first_start;
        logic [15:0]       second_start;
        logic [7:0]        row_count;
        logic [8:0]        column_count;
    } state_t;

    // Power-up state
    localparam state_t ST_RESET = '{
        init_index:      4'd0,
        initializing:    1'b1,
        busy:            1'b0,
        disp_enable:     1'b0,
        cursor_on:       1'b0,
        blanking:        1'b0,
        tick_phase:      3'd0,
        countdown:       '0,
        write_target:    '0,
        char_byte:       8'd0,
        attr_byte:       8'd0,
        pointer_address: '0,
        cursor_address:  '0,
        first_start:     16'd0,
        second_start:    16'd0,
        row_count:       8'd1,
        column_count:    9'd1
    };

    // Result beat, last member in the lowest bits
    typedef struct packed {
        logic [8:0]        columns_in_use;
        logic [7:0]        rows_in_use;
        logic              busy_now;
        logic              cursor_shown;
        logic              display_enabled;
        logic [7:0]        commit_color;
        logic [7:0]        commit_char;
        logic [ADDR_W-1:0] commit_addr;
        logic [7:0]        read_data;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

`default_nettype wire

### rtl/video_display_controller_regs_top.sv
// ============================================================================
// video_display_controller_regs_top
// Bus-side register model of a character video display controller.
// ============================================================================
//
//  channel  | role    | tdata                           | tuser
//  ---------+---------+---------------------------------+----------------
//  s_axis   | request | bus_addr, write_data            | req_type
//  m_axis   | result  | read, commit, flags, geometry   | commit_valid
//
//  One request is accepted per cycle while tready is high; its result is
//  registered into the result or skid beat. All decode is one pass of logic
//  from the controller state to the result register.
//  A two-beat output buffer (result plus skid) lets a request enter while a
//  result waits; tready drops only when both beats are held.
//  Reset loads the power-up state: index 0, initializing, rows and columns 1.
// ============================================================================
`default_nettype none

module video_display_controller_regs_top #(
    parameter int WRITE_DELAY = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [4:0] bus_addr, [12:5] write_data, [15:13] zero
    input  wire logic [15:0]  s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [7:0] read_data, [21:8] commit_addr, [29:22] commit_char,
    // [37:30] commit_color, [38] display_enabled, [39] cursor_shown,
    // [40] busy_now, [48:41] rows_in_use, [57:49] columns_in_use, [63:58] zero
    output logic [63:0]       m_axis_tdata,
    // [0] commit_valid
    output logic              m_axis_tuser
);
    import vdc_pkg::*;

    localparam logic [COUNT_W-1:0] DELAY_LOAD = COUNT_W'(WRITE_DELAY);

    state_t  st_reg, st_next;
    result_t res_next;
    logic    cv_next;

    result_t out_res_reg, skid_res_reg;
    logic    out_cv_reg, skid_cv_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic       in_fire, out_fire;
    req_t       req;
    logic [4:0] addr;
    logic [7:0] wdata;
    reg_sel_t   sel;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign req      = req_t'(s_axis_tuser);
    assign addr     = s_axis_tdata[4:0];
    assign wdata    = s_axis_tdata[12:5];
    assign sel      = reg_sel_t'(addr[2:0]);

    // Decode one request against the current state
    always_comb
    begin
        st_next  = st_reg;
        res_next = '0;
        cv_next  = 1'b0;
        unique case (req)
            REQ_WRITE:
            begin
                if (!addr[ADDR_CTRL_BIT])
                begin
                    if (addr[ADDR_COLOR_BIT])
                        st_next.attr_byte = wdata;
                    else
                        st_next.char_byte = wdata;
                end
                else
                begin
                    unique case (sel)
                        REG_INIT:
                        begin
                            // write the init register under the pointer
                            unique case (st_reg.init_index)
                                INIT_ROWS:   st_next.row_count = {1'b0, wdata[6:0]} + 8'd1;
                                INIT_COLS:   st_next.column_count = {1'b0, wdata} + 9'd1;
                                INIT_PTR_LO: st_next.pointer_address[7:0] = wdata;
                                INIT_PTR_HI: st_next.pointer_address[13:8] = wdata[5:0];
                                INIT_LAST:   st_next.initializing = 1'b0;
                                default:     ;
                            endcase
                            if (st_reg.init_index < INIT_LAST)
                                st_next.init_index = st_reg.init_index + 4'd1;
                        end
                        REG_CMD:
                        begin
                            // when not busy, apply every matching command action in order
                            if (!st_reg.busy)
                            begin
                                if (wdata == CMD_RESET)
                                begin
                                    st_next.init_index   = '0;
                                    st_next.busy         = 1'b0;
                                    st_next.countdown    = '0;
                                    st_next.initializing = 1'b1;
                                    st_next.disp_enable  = 1'b0;
                                    st_next.blanking     = 1'b0;
                                    st_next.tick_phase   = '0;
                                end
                                if ((wdata & MASK_SET_INDEX) == PAT_SET_INDEX)
                                    st_next.init_index = wdata[3:0];
                                if ((wdata & MASK_DISPLAY) == PAT_DISPLAY_OFF)
                                    st_next.disp_enable = 1'b0;
                                if ((wdata & MASK_DISPLAY) == PAT_DISPLAY_ON)
                                    st_next.disp_enable = 1'b1;
                                if ((wdata & MASK_CURSOR) == PAT_CURSOR_OFF)
                                    st_next.cursor_on = 1'b0;
                                if ((wdata & MASK_CURSOR) == PAT_CURSOR_ON)
                                    st_next.cursor_on = 1'b1;
                                if (wdata == CMD_WR_PTR)
                                begin
                                    st_next.write_target = st_reg.pointer_address;
                                    st_next.countdown    = DELAY_LOAD;
                                    st_next.busy         = 1'b1;
                                end
                                if (wdata == CMD_INC_CUR)
                                    st_next.cursor_address = st_reg.cursor_address + 14'd1;
                                if (wdata == CMD_WR_CUR || wdata == CMD_WR_CUR_INC)
                                begin
                                    st_next.write_target = st_reg.cursor_address;
                                    st_next.countdown    = DELAY_LOAD;
                                    st_next.busy         = 1'b1;
                                end
                                if (wdata == CMD_WR_CUR_INC)
                                    st_next.cursor_address = st_reg.cursor_address + 14'd1;
                            end
                        end
                        REG_FS_LO:  st_next.first_start[7:0] = wdata;
                        REG_FS_HI:  st_next.first_start[15:8] = wdata;
                        REG_CUR_LO: st_next.cursor_address[7:0] = wdata;
                        REG_CUR_HI: st_next.cursor_address[13:8] = wdata[5:0];
                        REG_SS_LO:  st_next.second_start[7:0] = wdata;
                        REG_SS_HI:  st_next.second_start[15:8] = wdata;
                    endcase
                end
            end
            REQ_READ:
            begin
                if (!addr[ADDR_CTRL_BIT])
                    res_next.read_data = RD_UNMAPPED;
                else
                begin
                    unique case (sel)
                        REG_INIT, REG_CMD:
                        begin
                            res_next.read_data = (st_reg.busy ? 8'h00 : STAT_READY)
                                               | (st_reg.blanking ? STAT_BLANK : 8'h00);
                            if (sel == REG_CMD && (!st_reg.busy || st_reg.initializing))
                                res_next.read_data = res_next.read_data | STAT_CMD_READY;
                        end
                        REG_FS_LO:  res_next.read_data = st_reg.first_start[7:0];
                        REG_FS_HI:  res_next.read_data = st_reg.first_start[15:8];
                        REG_CUR_LO: res_next.read_data = st_reg.cursor_address[7:0];
                        REG_CUR_HI: res_next.read_data = {2'b00, st_reg.cursor_address[13:8]};
                        REG_SS_LO:  res_next.read_data = st_reg.second_start[7:0];
                        REG_SS_HI:  res_next.read_data = {2'b00, st_reg.second_start[13:8]};
                    endcase
                end
            end
            REQ_TICK:
            begin
                // advance the blank phase and the delayed write
                st_next.tick_phase = st_reg.tick_phase + 3'd1;
                if (st_next.tick_phase == 3'd0)
                    st_next.blanking = !st_reg.blanking;
                if (st_reg.countdown != '0)
                begin
                    st_next.countdown = st_reg.countdown - COUNT_W'(1);
                    if (st_next.countdown == '0)
                    begin
                        cv_next               = 1'b1;
                        res_next.commit_addr  = st_reg.write_target;
                        res_next.commit_char  = st_reg.char_byte;
                        res_next.commit_color = st_reg.attr_byte;
                        st_next.busy          = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        res_next.display_enabled = st_next.disp_enable;
        res_next.cursor_shown    = st_next.cursor_on;
        res_next.busy_now        = st_next.busy;
        res_next.rows_in_use     = st_next.row_count;
        res_next.columns_in_use  = st_next.column_count;
    end

    // Update the controller state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
        end
        else if (in_fire)
        begin
            st_reg <= st_next;
        end
    end

    // Hold result and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load result payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_res_reg <= skid_res_reg;
                out_cv_reg  <= skid_cv_reg;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_res_reg <= res_next;
                skid_cv_reg  <= cv_next;
            end
            else
            begin
                out_res_reg <= res_next;
                out_cv_reg  <= cv_next;
            end
        end
    end

    assign s_axis_tready = !skid_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(64 - RES_W)'(0), out_res_reg};
    assign m_axis_tuser  = out_cv_reg;

endmodule

`default_nettype wire

### rtl/vdc_chk.sv
// ============================================================================
// vdc_chk
// Port-level checks on the result stream of the display controller block.
// ============================================================================
`default_nettype none

module vdc_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    import vdc_pkg::*;

    // Hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // A commit beat frees the controller and carries no read byte
    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[40] && m_axis_tdata[7:0] == 8'h00)
        else $error("commit beat shows busy or read data");

    // Commit fields stay zero without a commit
    a_commit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[37:8] == 30'd0)
        else $error("commit fields set without commit");

    // Geometry never reads as zero, padding stays clear
    a_geometry: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[48:41] != 8'd0 && m_axis_tdata[57:49] != 9'd0
            && m_axis_tdata[63:58] == 6'd0)
        else $error("bad geometry or padding");

    // An accepted request is answered on the next edge when the output is free
    a_answer: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready)
            && s_axis_tdata[15:13] == 3'd0 && s_axis_tuser != REQ_RSVD |=> m_axis_tvalid)
        else $error("accepted request not answered");

endmodule

bind video_display_controller_regs_top vdc_chk u_vdc_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/sv/tb_video_display_controller_regs_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_video_display_controller_regs_top
// Drives bus writes, bus reads and ticks into the register block and checks
// every result beat against a shadow of the controller state kept here. A
// short table of directed requests comes first, then random traffic biased
// toward command and init port writes with enough ticks to finish delayed
// writes. Both stream sides stall at random.
// ============================================================================

module tb_video_display_controller_regs_top;

    import vdc_pkg::*;

    localparam int WRITE_DELAY  = 8;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 16;

    // One expected result beat
    typedef struct packed {
        result_t res;
        logic    commit;
    } beat_t;

    // One row of the directed table
    typedef struct {
        logic [1:0] req;
        logic [4:0] addr;
        logic [7:0] data;
        int         reps;
        logic       typed;
        beat_t      typed_beat;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    // Shadow of the controller state
    logic [3:0]  ctl_index = 4'd0;
    logic        ctl_initializing = 1'b1;
    logic        ctl_busy = 1'b0;
    logic        ctl_display = 1'b0;
    logic        ctl_cursor_on = 1'b0;
    logic        ctl_blank = 1'b0;
    logic [2:0]  ctl_phase = 3'd0;
    logic [3:0]  ctl_countdown = 4'd0;
    logic [13:0] ctl_target = '0;
    logic [7:0]  ctl_char = '0;
    logic [7:0]  ctl_color = '0;
    logic [13:0] ctl_pointer = '0;
    logic [13:0] ctl_cursor = '0;
    logic [15:0] ctl_first = '0;
    logic [15:0] ctl_second = '0;
    logic [7:0]  ctl_rows = 8'd1;
    logic [8:0]  ctl_cols = 9'd1;

    beat_t       pending_results[$];
    stim_row_t   directed_rows[32];
    int          n_rows = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic        no_stall = 1'b0;
    beat_t       oldest;
    result_t     got;

    video_display_controller_regs_top #(
        .WRITE_DELAY(WRITE_DELAY)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one request to the shadow state and return the beat it produces
    function automatic beat_t decode_request(input logic [1:0] req, input logic [4:0] a,
                                             input logic [7:0] v);
        beat_t    b;
        reg_sel_t sel;
        logic [7:0] status;
        b = '0;
        sel = reg_sel_t'(a[2:0]);
        if (req == REQ_WRITE)
        begin
            if (!a[ADDR_CTRL_BIT])
            begin
                if (a[ADDR_COLOR_BIT])
                    ctl_color = v;
                else
                    ctl_char = v;
            end
            else
            begin
                case (sel)
                    REG_INIT:
                    begin
                        case (ctl_index)
                            INIT_ROWS:   ctl_rows = {1'b0, v[6:0]} + 8'd1;
                            INIT_COLS:   ctl_cols = {1'b0, v} + 9'd1;
                            INIT_PTR_LO: ctl_pointer[7:0] = v;
                            INIT_PTR_HI: ctl_pointer[13:8] = v[5:0];
                            INIT_LAST:   ctl_initializing = 1'b0;
                            default: ;
                        endcase
                        if (ctl_index < INIT_LAST)
                            ctl_index = ctl_index + 4'd1;
                    end
                    REG_CMD:
                    begin
                        // Commands are dropped while a delayed write is pending;
                        // every pattern that matches takes effect
                        if (!ctl_busy)
                        begin
                            if (v == CMD_RESET)
                            begin
                                ctl_index = 4'd0;
                                ctl_busy = 1'b0;
                                ctl_countdown = 4'd0;
                                ctl_initializing = 1'b1;
                                ctl_display = 1'b0;
                                ctl_blank = 1'b0;
                                ctl_phase = 3'd0;
                            end
                            if ((v & MASK_SET_INDEX) == PAT_SET_INDEX)
                                ctl_index = v[3:0];
                            if ((v & MASK_DISPLAY) == PAT_DISPLAY_OFF)
                                ctl_display = 1'b0;
                            if ((v & MASK_DISPLAY) == PAT_DISPLAY_ON)
                                ctl_display = 1'b1;
                            if ((v & MASK_CURSOR) == PAT_CURSOR_OFF)
                                ctl_cursor_on = 1'b0;
                            if ((v & MASK_CURSOR) == PAT_CURSOR_ON)
                                ctl_cursor_on = 1'b1;
                            if (v == CMD_WR_PTR || v == CMD_WR_CUR || v == CMD_WR_CUR_INC)
                            begin
                                ctl_target = (v == CMD_WR_PTR) ? ctl_pointer : ctl_cursor;
                                ctl_countdown = 4'(WRITE_DELAY);
                                ctl_busy = 1'b1;
                            end
                            if (v == CMD_INC_CUR || v == CMD_WR_CUR_INC)
                                ctl_cursor = ctl_cursor + 14'd1;
                        end
                    end
                    REG_FS_LO:  ctl_first[7:0] = v;
                    REG_FS_HI:  ctl_first[15:8] = v;
                    REG_CUR_LO: ctl_cursor[7:0] = v;
                    REG_CUR_HI: ctl_cursor[13:8] = v[5:0];
                    REG_SS_LO:  ctl_second[7:0] = v;
                    default:    ctl_second[15:8] = v;
                endcase
            end
        end
        else if (req == REQ_READ)
        begin
            if (!a[ADDR_CTRL_BIT])
                b.res.read_data = RD_UNMAPPED;
            else
            begin
                case (sel)
                    REG_INIT, REG_CMD:
                    begin
                        status = (ctl_busy ? 8'h00 : STAT_READY) |
                                 (ctl_blank ? STAT_BLANK : 8'h00);
                        if (sel == REG_CMD && (!ctl_busy || ctl_initializing))
                            status = status | STAT_CMD_READY;
                        b.res.read_data = status;
                    end
                    REG_FS_LO:  b.res.read_data = ctl_first[7:0];
                    REG_FS_HI:  b.res.read_data = ctl_first[15:8];
                    REG_CUR_LO: b.res.read_data = ctl_cursor[7:0];
                    REG_CUR_HI: b.res.read_data = {2'b00, ctl_cursor[13:8]};
                    REG_SS_LO:  b.res.read_data = ctl_second[7:0];
                    default:    b.res.read_data = {2'b00, ctl_second[13:8]};
                endcase
            end
        end
        else if (req == REQ_TICK)
        begin
            // Toggle blanking every eighth tick, count down a pending write
            ctl_phase = ctl_phase + 3'd1;
            if (ctl_phase == 3'd0)
                ctl_blank = ~ctl_blank;
            if (ctl_countdown != 4'd0)
            begin
                ctl_countdown = ctl_countdown - 4'd1;
                if (ctl_countdown == 4'd0)
                begin
                    b.commit = 1'b1;
                    b.res.commit_addr = ctl_target;
                    b.res.commit_char = ctl_char;
                    b.res.commit_color = ctl_color;
                    ctl_busy = 1'b0;
                end
            end
        end
        b.res.display_enabled = ctl_display;
        b.res.cursor_shown = ctl_cursor_on;
        b.res.busy_now = ctl_busy;
        b.res.rows_in_use = ctl_rows;
        b.res.columns_in_use = ctl_cols;
        return b;
    endfunction

    // Beat of a read straight after reset
    function automatic beat_t reset_read(input logic [7:0] rd);
        beat_t b;
        b = '0;
        b.res.read_data = rd;
        b.res.rows_in_use = 8'd1;
        b.res.columns_in_use = 9'd1;
        return b;
    endfunction

    function void check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
            mismatch_count++;
        end
    endfunction

    task automatic add_row(input logic [1:0] req, input logic [4:0] addr,
                           input logic [7:0] data, input int reps);
        directed_rows[n_rows].req = req;
        directed_rows[n_rows].addr = addr;
        directed_rows[n_rows].data = data;
        directed_rows[n_rows].reps = reps;
        directed_rows[n_rows].typed = 1'b0;
        directed_rows[n_rows].typed_beat = '0;
        n_rows++;
    endtask

    task automatic add_typed(input logic [1:0] req, input logic [4:0] addr,
                             input logic [7:0] data, input beat_t b);
        add_row(req, addr, data, 1);
        directed_rows[n_rows - 1].typed = 1'b1;
        directed_rows[n_rows - 1].typed_beat = b;
    endtask

    // Present one request, hold it until accepted, return its predicted beat
    task automatic send_request(input logic [1:0] req, input logic [4:0] addr,
                                input logic [7:0] data, output beat_t pred);
        while (!no_stall && $urandom_range(0, 99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, data, addr};
        s_axis_tuser <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = decode_request(req, addr, data);
    endtask

    // Hold off the sender until every expected beat has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Check result beats and stall the receiver
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none actual %0h/%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                got = result_t'(m_axis_tdata[RES_W-1:0]);
                check_field("commit_valid", 32'(oldest.commit), 32'(m_axis_tuser));
                check_field("read_data", 32'(oldest.res.read_data), 32'(got.read_data));
                check_field("commit_addr", 32'(oldest.res.commit_addr),
                            32'(got.commit_addr));
                check_field("commit_char", 32'(oldest.res.commit_char),
                            32'(got.commit_char));
                check_field("commit_color", 32'(oldest.res.commit_color),
                            32'(got.commit_color));
                check_field("display_enabled", 32'(oldest.res.display_enabled),
                            32'(got.display_enabled));
                check_field("cursor_shown", 32'(oldest.res.cursor_shown),
                            32'(got.cursor_shown));
                check_field("busy_now", 32'(oldest.res.busy_now), 32'(got.busy_now));
                check_field("rows_in_use", 32'(oldest.res.rows_in_use),
                            32'(got.rows_in_use));
                check_field("columns_in_use", 32'(oldest.res.columns_in_use),
                            32'(got.columns_in_use));
            end
        end
        m_axis_tready <= no_stall || ($urandom_range(0, 99) >= 32);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        beat_t      pred;
        logic [1:0] req;
        logic [4:0] addr;
        logic [7:0] data;
        int         pick;
        int         sub;

        // Status and unmapped reads out of reset
        add_typed(REQ_READ, 5'h11, 8'h00, reset_read(8'h22));
        add_typed(REQ_READ, 5'h00, 8'hFF, reset_read(RD_UNMAPPED));
        add_typed(REQ_READ, 5'h10, 8'h00, reset_read(STAT_READY));
        // Latches at their extremes
        add_row(REQ_WRITE, 5'h07, 8'hFF, 1);
        add_row(REQ_WRITE, 5'h0F, 8'h80, 1);
        // Largest row and column counts, aliased init port address
        add_row(REQ_WRITE, 5'h11, PAT_SET_INDEX | {4'h0, INIT_ROWS}, 1);
        add_row(REQ_WRITE, 5'h10, 8'hFF, 1);
        add_row(REQ_WRITE, 5'h18, 8'hFF, 1);
        // Pointer address all ones
        add_row(REQ_WRITE, 5'h11, PAT_SET_INDEX | {4'h0, INIT_PTR_LO}, 1);
        add_row(REQ_WRITE, 5'h10, 8'hFF, 2);
        // End of init, write at the stop index, then index fifteen
        add_row(REQ_WRITE, 5'h11, PAT_SET_INDEX | {4'h0, INIT_LAST}, 1);
        add_row(REQ_WRITE, 5'h10, 8'h00, 2);
        add_row(REQ_WRITE, 5'h11, PAT_SET_INDEX | 8'h0F, 1);
        add_row(REQ_WRITE, 5'h10, 8'h7F, 1);
        // Display and cursor on
        add_row(REQ_WRITE, 5'h11, PAT_DISPLAY_ON, 1);
        add_row(REQ_WRITE, 5'h19, PAT_CURSOR_ON | 8'h0E, 1);
        // Cursor at the top address, delayed write with wrap of the increment
        add_row(REQ_WRITE, 5'h14, 8'hFF, 1);
        add_row(REQ_WRITE, 5'h15, 8'hFF, 1);
        add_row(REQ_WRITE, 5'h11, CMD_WR_CUR_INC, 1);
        // Command while busy is dropped; status shows busy
        add_row(REQ_WRITE, 5'h11, PAT_DISPLAY_OFF, 1);
        add_row(REQ_READ, 5'h11, 8'h00, 1);
        add_row(REQ_READ, 5'h15, 8'h00, 1);
        // Run out the delay, then an unknown request kind and a reset command
        add_row(REQ_TICK, 5'h1F, 8'hFF, WRITE_DELAY);
        add_row(REQ_RSVD, 5'h1F, 8'hFF, 1);
        add_row(REQ_WRITE, 5'h11, CMD_RESET, 1);
        add_row(REQ_READ, 5'h11, 8'h00, 1);

        // Reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int r = 0; r < n_rows; r++)
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                send_request(directed_rows[r].req, directed_rows[r].addr,
                             directed_rows[r].data, pred);
                pending_results.push_back(directed_rows[r].typed ?
                                          directed_rows[r].typed_beat : pred);
            end
        end
        drain_results();

        // Random traffic
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 700)
                no_stall = 1'b1;
            if (i == 1100)
                no_stall = 1'b0;
            if (i == 1400)
                drain_results();
            pick = $urandom_range(0, 99);
            sub = $urandom_range(0, 99);
            data = 8'($urandom_range(0, 255));
            addr = 5'($urandom_range(0, 31));
            if (pick < 30)
                req = REQ_TICK;
            else if (pick < 50)
                req = REQ_READ;
            else if (pick < 52)
                req = REQ_RSVD;
            else
            begin
                req = REQ_WRITE;
                if (sub < 20)
                    addr[ADDR_CTRL_BIT] = 1'b0;
                else if (sub < 65)
                begin
                    addr[ADDR_CTRL_BIT] = 1'b1;
                    addr[2:0] = (sub < 45) ? REG_CMD : REG_INIT;
                end
                else
                    addr[ADDR_CTRL_BIT] = 1'b1;
                // Bias command port writes toward real command codes
                if (sub >= 20 && sub < 45)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3)
                        data = CMD_RESET;
                    else if (pick < 15)
                        data = PAT_SET_INDEX | (data & 8'h0F);
                    else if (pick < 30)
                        data = (data & 8'h16) | (data[0] ? PAT_DISPLAY_ON : PAT_DISPLAY_OFF);
                    else if (pick < 45)
                        data = (data & 8'h0E) | (data[7] ? PAT_CURSOR_ON : PAT_CURSOR_OFF);
                    else if (pick < 55)
                        data = CMD_WR_PTR;
                    else if (pick < 65)
                        data = CMD_INC_CUR;
                    else if (pick < 75)
                        data = CMD_WR_CUR;
                    else if (pick < 85)
                        data = CMD_WR_CUR_INC;
                end
            end
            send_request(req, addr, data, pred);
            pending_results.push_back(pred);
        end

        // Wait out the last results
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
